@@ rtl/guest_memory_map_decoder_macros.svh @@
// Assertion macros shared by the decoder's checker.
// Needs nothing else; include by bare file name.
`ifndef GUEST_MEMORY_MAP_DECODER_MACROS_SVH
`define GUEST_MEMORY_MAP_DECODER_MACROS_SVH

// same-cycle implication, disabled in reset
`define GMMD_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("gmmd assertion failed");

// next-cycle implication, disabled in reset
`define GMMD_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("gmmd assertion failed");

`endif

@@ rtl/gmmd_pkg.sv @@
// Shared types, codes and data conversion functions for the guest memory map decoder.
// No dependencies.
package gmmd_pkg;

  localparam int HOST_BIG_ENDIAN_DEF = 0;
  localparam int BANK_SHIFT_DEF      = 16;
  localparam int CFG_INDEX_W         = 3;

  localparam logic [2:0] OP_RD_B = 3'd0;
  localparam logic [2:0] OP_RD_W = 3'd1;
  localparam logic [2:0] OP_RD_L = 3'd2;
  localparam logic [2:0] OP_WR_B = 3'd3;
  localparam logic [2:0] OP_WR_W = 3'd4;
  localparam logic [2:0] OP_WR_L = 3'd5;

  localparam logic [1:0] REGION_EMPTY = 2'd0;
  localparam logic [1:0] REGION_RAM   = 2'd1;
  localparam logic [1:0] REGION_ROM   = 2'd2;
  localparam logic [1:0] REGION_FRAME = 2'd3;

  localparam logic [1:0] W_BYTE = 2'd0;
  localparam logic [1:0] W_HALF = 2'd1;
  localparam logic [1:0] W_LONG = 2'd2;

  localparam logic [1:0] FB_DIRECT = 2'd0;
  localparam logic [1:0] FB_555    = 2'd1;
  localparam logic [1:0] FB_565    = 2'd2;
  localparam logic [1:0] FB_888    = 2'd3;

  localparam logic [CFG_INDEX_W-1:0] CFG_ADDR24      = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_RAM_BASE    = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_RAM_BYTES   = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_ROM_BASE    = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_ROM_BYTES   = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_BASE  = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_BYTES = 3'd6;
  localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_LAYOUT = 3'd7;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [31:0] address;
    logic [31:0] write_data;
    logic [31:0] store_data;
  } in_t;

  typedef struct packed {
    logic [1:0]  region;
    logic [31:0] offset;
    logic        store_write;
    logic [31:0] data_out;
  } out_t;

  typedef struct packed {
    logic        addressing_24bit;
    logic [31:0] ram_base;
    logic [31:0] ram_bytes;
    logic [31:0] rom_base;
    logic [31:0] rom_bytes;
    logic [31:0] frame_base;
    logic [31:0] frame_bytes;
    logic [1:0]  frame_layout;
  } cfg_t;

  // classified access, queued between front and back
  typedef struct packed {
    logic [1:0]  region;
    logic [31:0] eff;
    logic [31:0] base;
    logic [2:0]  opcode;
    logic [31:0] write_data;
    logic [31:0] store_data;
  } cls_t;

  function automatic logic [1:0] access_width(logic [2:0] op);
    logic [1:0] w;
    unique case (op)
      OP_RD_B, OP_WR_B: w = W_BYTE;
      OP_RD_W, OP_WR_W: w = W_HALF;
      OP_RD_L, OP_WR_L: w = W_LONG;
      default:          w = W_BYTE;
    endcase
    return w;
  endfunction

  function automatic logic [31:0] half_swap(logic [31:0] v, logic hbe);
    return hbe ? v : {v[15:0], v[31:16]};
  endfunction

  function automatic logic [31:0] endian_conv(logic [31:0] v, logic [1:0] w, logic hbe);
    logic [31:0] r;
    unique case (w)
      W_BYTE:  r = {24'h0, v[7:0]};
      W_HALF:  r = hbe ? {16'h0, v[15:0]} : {16'h0, v[7:0], v[15:8]};
      default: r = hbe ? v : {v[7:0], v[15:8], v[23:16], v[31:24]};
    endcase
    return r;
  endfunction

  function automatic logic [31:0] frame_read(logic [31:0] sd, logic [1:0] w, logic a24,
                                             logic [1:0] layout, logic hbe);
    logic [31:0] l;
    logic [31:0] r;
    if (a24 || layout == FB_DIRECT || w == W_BYTE) begin
      r = endian_conv(sd, w, hbe);
    end else if (layout == FB_888) begin
      r = (w == W_LONG) ? sd : endian_conv(sd, w, hbe);
    end else if (layout == FB_555) begin
      r = (w == W_LONG) ? half_swap(sd, hbe) : {16'h0, sd[15:0]};
    end else if (w == W_LONG) begin
      l = (sd & 32'h001f001f) | ((sd >> 1) & 32'h7fe07fe0);
      r = half_swap(l, hbe);
    end else begin
      l = {16'h0, sd[15:0]};
      r = (l & 32'h0000001f) | ((l >> 1) & 32'h00007fe0);
    end
    return r;
  endfunction

  function automatic logic [31:0] frame_write(logic [31:0] wd, logic [1:0] w, logic a24,
                                              logic [1:0] layout, logic hbe);
    logic [31:0] l;
    logic [31:0] r;
    if (a24 || layout == FB_DIRECT || w == W_BYTE) begin
      r = endian_conv(wd, w, hbe);
    end else if (layout == FB_888) begin
      r = (w == W_LONG) ? wd : endian_conv(wd, w, hbe);
    end else if (layout == FB_555) begin
      r = (w == W_LONG) ? half_swap(wd, hbe) : {16'h0, wd[15:0]};
    end else if (w == W_LONG) begin
      l = (wd & 32'h001f001f) | ((wd << 1) & 32'hffc0ffc0);
      r = half_swap(l, hbe);
    end else begin
      l = {16'h0, wd[15:0]};
      r = ((l & 32'h0000001f) | ((l << 1) & 32'h0000ffc0)) & 32'h0000ffff;
    end
    return r;
  endfunction

endpackage

@@ rtl/gmmd_fifo.sv @@
// Two-entry queue of classified accesses between the front and back halves.
// Depends on gmmd_pkg.
module gmmd_fifo (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  gmmd_pkg::cls_t push_data,
  input  logic          pop,
  output gmmd_pkg::cls_t head,
  output logic          head_valid,
  output logic          full
);
  import gmmd_pkg::*;

  localparam int DEPTH = 2;
  localparam int PW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);

  cls_t          mem [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign head       = mem[rd_ptr];
  assign head_valid = (count != '0);
  assign full       = (count == CW'(DEPTH));

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

@@ rtl/gmmd_front.sv @@
// Front half: takes input beats and classifies them by bank into a region.
// Depends on gmmd_pkg.
module gmmd_front #(
  parameter int BANK_SHIFT = gmmd_pkg::BANK_SHIFT_DEF
) (
  input  gmmd_pkg::cfg_t cfg,
  input  logic           in_valid,
  input  gmmd_pkg::in_t  in_data,
  input  logic           queue_full,
  output logic           in_stall,
  output logic           push,
  output gmmd_pkg::cls_t cls
);
  import gmmd_pkg::*;

  localparam int BW = 32 - BANK_SHIFT;
  localparam int MW = 24 - BANK_SHIFT;
  localparam logic [BW:0]   MIRROR_BANKS = {{BW{1'b0}}, 1'b1} << MW;
  localparam logic [BW-1:0] MIRROR_MASK  = MIRROR_BANKS[BW-1:0] - {{(BW-1){1'b0}}, 1'b1};

  function automatic logic in_region(logic [BW-1:0] bank, logic [BW-1:0] start,
                                     logic [BW:0] size, logic a24);
    logic [BW-1:0] diff;
    logic          hit;
    diff = bank - start;
    if (a24 && ({1'b0, start} < MIRROR_BANKS)) begin
      hit = (size >= MIRROR_BANKS) || ({1'b0, diff & MIRROR_MASK} < size);
    end else begin
      hit = ({1'b0, diff} < size);
    end
    return hit;
  endfunction

  logic [BW-1:0] bank;
  logic [31:0]   ram_clip;
  logic [BW:0]   ram_sz;
  logic [BW:0]   rom_sz;
  logic [BW:0]   frame_sz;
  logic          is_write;
  logic [1:0]    region;

  assign in_stall = queue_full;
  assign push     = in_valid && !queue_full;

  assign bank     = in_data.address[31:BANK_SHIFT];
  assign ram_clip = (cfg.ram_bytes > cfg.rom_base) ? cfg.rom_base : cfg.ram_bytes;
  assign ram_sz   = {1'b0, ram_clip[31:BANK_SHIFT]};
  assign rom_sz   = {1'b0, cfg.rom_bytes[31:BANK_SHIFT]};
  assign frame_sz = {1'b0, cfg.frame_bytes[31:BANK_SHIFT]} + {{BW{1'b0}}, 1'b1};
  assign is_write = (in_data.opcode >= OP_WR_B) && (in_data.opcode <= OP_WR_L);

  always_comb begin
    priority if (in_region(bank, cfg.frame_base[31:BANK_SHIFT], frame_sz,
                           cfg.addressing_24bit)) begin
      region = REGION_FRAME;
    end else if (in_region(bank, cfg.rom_base[31:BANK_SHIFT], rom_sz,
                           cfg.addressing_24bit)) begin
      region = REGION_ROM;
    end else if (in_region(bank, cfg.ram_base[31:BANK_SHIFT], ram_sz,
                           cfg.addressing_24bit)) begin
      region = REGION_RAM;
    end else begin
      region = REGION_EMPTY;
    end
  end

  always_comb begin
    cls.region     = region;
    cls.opcode     = in_data.opcode;
    cls.write_data = in_data.write_data;
    cls.store_data = in_data.store_data;
    unique case (region)
      REGION_RAM:   cls.base = cfg.ram_base;
      REGION_ROM:   cls.base = cfg.rom_base;
      REGION_FRAME: cls.base = cfg.frame_base;
      default:      cls.base = '0;
    endcase
    // frame writes keep the full address
    if (cfg.addressing_24bit && region != REGION_EMPTY &&
        !(region == REGION_FRAME && is_write)) begin
      cls.eff = {8'h0, in_data.address[23:0]};
    end else begin
      cls.eff = in_data.address;
    end
  end

endmodule

@@ rtl/gmmd_back.sv @@
// Back half: forms offset, write enable and converted data into the output register.
// Depends on gmmd_pkg.
module gmmd_back #(
  parameter int HOST_BIG_ENDIAN = gmmd_pkg::HOST_BIG_ENDIAN_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  gmmd_pkg::cfg_t cfg,
  input  gmmd_pkg::cls_t head,
  input  logic           head_valid,
  output logic           pop,
  output logic           out_valid,
  input  logic           out_stall,
  output gmmd_pkg::out_t out_data
);
  import gmmd_pkg::*;

  localparam logic HBE = (HOST_BIG_ENDIAN != 0);

  logic [1:0]  w;
  logic        op_valid;
  logic        is_write;
  out_t        result;

  assign pop      = head_valid && (!out_valid || !out_stall);
  assign w        = access_width(head.opcode);
  assign op_valid = (head.opcode <= OP_WR_L);
  assign is_write = op_valid && (head.opcode >= OP_WR_B);

  always_comb begin
    result.region      = head.region;
    result.offset      = head.eff - head.base;
    result.store_write = 1'b0;
    result.data_out    = '0;
    if (op_valid) begin
      if (!is_write) begin
        unique case (head.region)
          REGION_RAM, REGION_ROM: result.data_out = endian_conv(head.store_data, w, HBE);
          REGION_FRAME: result.data_out = frame_read(head.store_data, w,
                                                     cfg.addressing_24bit,
                                                     cfg.frame_layout, HBE);
          default: result.data_out = '0;
        endcase
      end else begin
        unique case (head.region)
          REGION_RAM: begin
            result.data_out    = endian_conv(head.write_data, w, HBE);
            result.store_write = 1'b1;
          end
          REGION_FRAME: begin
            result.data_out    = frame_write(head.write_data, w, cfg.addressing_24bit,
                                             cfg.frame_layout, HBE);
            result.store_write = 1'b1;
          end
          default: result.data_out = '0;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || !out_stall) begin
      out_valid <= head_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_data <= result;
    end
  end

endmodule

@@ rtl/guest_memory_map_decoder.sv @@
// Guest memory map decoder: one access beat in, one result beat out, registered in the
// queue, then the output register; one beat per cycle sustained while out_stall is low.
// The front half classifies in the accept cycle, a two-entry queue decouples it from the
// back half, which registers the result. in_stall rises only when that queue is full.
// Synchronous reset clears all configuration registers to zero and empties queue and
// output register.
// Top level; depends on gmmd_pkg, gmmd_front, gmmd_fifo and gmmd_back.
module guest_memory_map_decoder #(
  parameter int HOST_BIG_ENDIAN = gmmd_pkg::HOST_BIG_ENDIAN_DEF,
  parameter int BANK_SHIFT      = gmmd_pkg::BANK_SHIFT_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  gmmd_pkg::in_t                      in_data,
  output logic                               out_valid,
  input  logic                               out_stall,
  output gmmd_pkg::out_t                     out_data,
  input  logic                               cfg_write,
  input  logic [gmmd_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [31:0]                        cfg_data
);
  import gmmd_pkg::*;

  cfg_t cfg;
  cls_t cls;
  cls_t head;
  logic push;
  logic pop;
  logic head_valid;
  logic queue_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_ADDR24:       cfg.addressing_24bit <= cfg_data[0];
        CFG_RAM_BASE:     cfg.ram_base         <= cfg_data;
        CFG_RAM_BYTES:    cfg.ram_bytes        <= cfg_data;
        CFG_ROM_BASE:     cfg.rom_base         <= cfg_data;
        CFG_ROM_BYTES:    cfg.rom_bytes        <= cfg_data;
        CFG_FRAME_BASE:   cfg.frame_base       <= cfg_data;
        CFG_FRAME_BYTES:  cfg.frame_bytes      <= cfg_data;
        CFG_FRAME_LAYOUT: cfg.frame_layout     <= cfg_data[1:0];
      endcase
    end
  end

  gmmd_front #(
    .BANK_SHIFT (BANK_SHIFT)
  ) u_front (
    .cfg        (cfg),
    .in_valid   (in_valid),
    .in_data    (in_data),
    .queue_full (queue_full),
    .in_stall   (in_stall),
    .push       (push),
    .cls        (cls)
  );

  gmmd_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_data  (cls),
    .pop        (pop),
    .head       (head),
    .head_valid (head_valid),
    .full       (queue_full)
  );

  gmmd_back #(
    .HOST_BIG_ENDIAN (HOST_BIG_ENDIAN)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

endmodule

@@ rtl/gmmd_checker.sv @@
// Port-level checks for the guest memory map decoder, bound to the top level.
// Depends on gmmd_pkg and guest_memory_map_decoder_macros.svh.
`include "guest_memory_map_decoder_macros.svh"

module gmmd_checker (
  input logic           clk,
  input logic           rst,
  input logic           in_valid,
  input logic           in_stall,
  input gmmd_pkg::in_t  in_data,
  input logic           out_valid,
  input logic           out_stall,
  input gmmd_pkg::out_t out_data
);
  import gmmd_pkg::*;

  `GMMD_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(out_data))

  `GMMD_ASSERT_NEXT(a_in_hold, clk, rst, in_valid && in_stall, in_valid && $stable(in_data))

  `GMMD_ASSERT_NOW(a_write_region, clk, rst, out_valid && out_data.store_write, out_data.region == REGION_RAM || out_data.region == REGION_FRAME)

  `GMMD_ASSERT_NOW(a_empty_zero, clk, rst, out_valid && out_data.region == REGION_EMPTY, out_data.data_out == 32'h0 && !out_data.store_write)

  // a fresh result beat comes from a beat accepted at the input, via the queue and the output register
  `GMMD_ASSERT_NOW(a_rise_src, clk, rst, $rose(out_valid), $past(in_valid && !in_stall, 2))

endmodule

bind guest_memory_map_decoder gmmd_checker u_gmmd_checker (.*);

@@ verif/tb_top.sv @@
// Self-checking testbench for guest_memory_map_decoder: random and directed access beats,
// a scoreboard that predicts region, offset, store write and converted data per beat.
// Depends on gmmd_pkg and the decoder RTL only.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import gmmd_pkg::*;

  localparam int BANK_SHIFT     = BANK_SHIFT_DEF;
  localparam bit HOST_BE        = HOST_BIG_ENDIAN_DEF != 0;
  localparam int SPACE_BANKS    = 1 << (32 - BANK_SHIFT);
  localparam int MIRROR_BANKS   = 1 << (24 - BANK_SHIFT);
  localparam logic [2:0] OP_NOP6 = 3'd6;
  localparam logic [2:0] OP_NOP7 = 3'd7;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int HOLD_CYCLES    = 400;

  class access_scoreboard;
    cfg_t        cfg;
    out_t        pending_results[$];
    int unsigned failures;

    function void set_reg(logic [CFG_INDEX_W-1:0] idx, logic [31:0] v);
      case (idx)
        CFG_ADDR24:       cfg.addressing_24bit = v[0];
        CFG_RAM_BASE:     cfg.ram_base = v;
        CFG_RAM_BYTES:    cfg.ram_bytes = v;
        CFG_ROM_BASE:     cfg.rom_base = v;
        CFG_ROM_BYTES:    cfg.rom_bytes = v;
        CFG_FRAME_BASE:   cfg.frame_base = v;
        CFG_FRAME_BYTES:  cfg.frame_bytes = v;
        CFG_FRAME_LAYOUT: cfg.frame_layout = v[1:0];
        default: ;
      endcase
    endfunction

    function bit bank_hit(int unsigned bank, int unsigned start, int unsigned size);
      if (cfg.addressing_24bit && start < MIRROR_BANKS) begin
        if (size >= MIRROR_BANKS) return 1;
        return ((bank - start) & (MIRROR_BANKS - 1)) < size;
      end
      if (size >= SPACE_BANKS) return 1;
      return ((bank - start) & (SPACE_BANKS - 1)) < size;
    endfunction

    // big-endian guest value <-> host value of one width
    function logic [31:0] guest_order(logic [31:0] v, logic [1:0] w);
      if (w == W_BYTE) return {24'h0, v[7:0]};
      if (w == W_HALF) return HOST_BE ? {16'h0, v[15:0]} : {16'h0, v[7:0], v[15:8]};
      return HOST_BE ? v : {v[7:0], v[15:8], v[23:16], v[31:24]};
    endfunction

    function logic [31:0] swap_halves(logic [31:0] v);
      return HOST_BE ? v : {v[15:0], v[31:16]};
    endfunction

    function logic [31:0] frame_data(logic [31:0] v, logic [1:0] w, bit to_store);
      if (cfg.addressing_24bit || cfg.frame_layout == FB_DIRECT || w == W_BYTE)
        return guest_order(v, w);
      case (cfg.frame_layout)
        FB_888: return (w == W_LONG) ? v : guest_order(v, w);
        FB_555: return (w == W_LONG) ? swap_halves(v) : {16'h0, v[15:0]};
        default: begin
          if (to_store) begin
            if (w == W_LONG)
              return swap_halves({v[30:21], 1'b0, v[20:16], v[14:5], 1'b0, v[4:0]});
            return {16'h0, v[14:5], 1'b0, v[4:0]};
          end
          if (w == W_LONG)
            return swap_halves({1'b0, v[31:22], v[20:16], 1'b0, v[15:6], v[4:0]});
          return {16'h0, 1'b0, v[15:6], v[4:0]};
        end
      endcase
    endfunction

    function out_t decode_access(in_t a);
      out_t        r;
      int unsigned bank;
      logic [31:0] ram_clip;
      logic [31:0] base;
      logic [1:0]  w;
      bit          is_write;
      bit          is_nop;
      bank     = a.address >> BANK_SHIFT;
      ram_clip = (cfg.ram_bytes > cfg.rom_base) ? cfg.rom_base : cfg.ram_bytes;
      is_write = a.opcode == OP_WR_B || a.opcode == OP_WR_W || a.opcode == OP_WR_L;
      is_nop   = a.opcode == OP_NOP6 || a.opcode == OP_NOP7;
      case (a.opcode)
        OP_RD_W, OP_WR_W, OP_NOP7: w = W_HALF;
        OP_RD_L, OP_WR_L:          w = W_LONG;
        default:                   w = W_BYTE;
      endcase
      r = '0;
      if (bank_hit(bank, cfg.frame_base >> BANK_SHIFT, (cfg.frame_bytes >> BANK_SHIFT) + 1))
        r.region = REGION_FRAME;
      else if (bank_hit(bank, cfg.rom_base >> BANK_SHIFT, cfg.rom_bytes >> BANK_SHIFT))
        r.region = REGION_ROM;
      else if (bank_hit(bank, cfg.ram_base >> BANK_SHIFT, ram_clip >> BANK_SHIFT))
        r.region = REGION_RAM;
      else
        r.region = REGION_EMPTY;
      case (r.region)
        REGION_RAM:   base = cfg.ram_base;
        REGION_ROM:   base = cfg.rom_base;
        REGION_FRAME: base = cfg.frame_base;
        default:      base = '0;
      endcase
      r.offset = a.address;
      // frame writes keep the full address in 24-bit mode
      if (cfg.addressing_24bit && r.region != REGION_EMPTY &&
          !(r.region == REGION_FRAME && is_write))
        r.offset = {8'h0, a.address[23:0]};
      r.offset = r.offset - base;
      if (!is_nop) begin
        case (r.region)
          REGION_RAM: begin
            if (is_write) begin
              r.data_out    = guest_order(a.write_data, w);
              r.store_write = 1'b1;
            end else begin
              r.data_out = guest_order(a.store_data, w);
            end
          end
          REGION_ROM: begin
            if (!is_write) r.data_out = guest_order(a.store_data, w);
          end
          REGION_FRAME: begin
            if (is_write) begin
              r.data_out    = frame_data(a.write_data, w, 1'b1);
              r.store_write = 1'b1;
            end else begin
              r.data_out = frame_data(a.store_data, w, 1'b0);
            end
          end
          default: ;
        endcase
      end
      return r;
    endfunction

    function void flag(string msg);
      failures++;
      if (failures <= 10) $display("%s", msg);
    endfunction

    function void note_access(in_t a);
      pending_results.push_back(decode_access(a));
    endfunction

    function void check_result(out_t got);
      out_t exp;
      if (pending_results.size() == 0) begin
        flag($sformatf("unexpected result beat: region %0d offset %h write %b data %h",
                       got.region, got.offset, got.store_write, got.data_out));
        return;
      end
      exp = pending_results.pop_front();
      if (got.region !== exp.region || got.offset !== exp.offset ||
          got.store_write !== exp.store_write || got.data_out !== exp.data_out)
        flag($sformatf({"mismatch: exp region %0d offset %h write %b data %h,",
                        " got region %0d offset %h write %b data %h"},
                       exp.region, exp.offset, exp.store_write, exp.data_out,
                       got.region, got.offset, got.store_write, got.data_out));
    endfunction

    function void finish_check();
      if (pending_results.size() != 0)
        flag($sformatf("%0d result beats never arrived", pending_results.size()));
    endfunction
  endclass

  logic                   clk;
  logic                   rst = 1'b1;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  in_t                    in_data = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  out_t                   out_data;
  logic                   cfg_write = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [31:0]            cfg_data = '0;

  access_scoreboard sb = new;
  bit               hold_off = 1'b0;
  int unsigned      quiet_cycles = 0;

  guest_memory_map_decoder uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall) sb.note_access(in_data);
    if (!rst && out_valid && !out_stall) sb.check_result(out_data);
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == WATCHDOG_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // receiver: stretches of no stall, light, heavy and toggling stall, one long hold-off
  initial begin
    int mode;
    int span;
    wait (!rst);
    @(posedge clk);
    forever begin
      if (hold_off) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off = 1'b0;
      end
      mode = $urandom_range(0, 3);
      span = $urandom_range(5, 120);
      repeat (span) begin
        case (mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 3) == 0);
          2: out_stall <= ($urandom_range(0, 3) != 0);
          default: out_stall <= ~out_stall;
        endcase
        @(posedge clk);
      end
    end
  end

  // called at a rising edge; returns at the edge where the beat is taken
  task automatic drive_beat(in_t a);
    in_valid <= 1'b1;
    in_data  <= a;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic idle_input(int n);
    in_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [31:0] v);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    sb.set_reg(idx, v);
    @(posedge clk);
  endtask

  task automatic load_config(cfg_t c);
    write_reg(CFG_ADDR24, {31'h0, c.addressing_24bit});
    write_reg(CFG_RAM_BASE, c.ram_base);
    write_reg(CFG_RAM_BYTES, c.ram_bytes);
    write_reg(CFG_ROM_BASE, c.rom_base);
    write_reg(CFG_ROM_BYTES, c.rom_bytes);
    write_reg(CFG_FRAME_BASE, c.frame_base);
    write_reg(CFG_FRAME_BYTES, c.frame_bytes);
    write_reg(CFG_FRAME_LAYOUT, {30'h0, c.frame_layout});
    cfg_write <= 1'b0;
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  function automatic cfg_t make_cfg(logic a24, logic [31:0] ram_b, logic [31:0] ram_n,
                                    logic [31:0] rom_b, logic [31:0] rom_n,
                                    logic [31:0] fb_b, logic [31:0] fb_n, logic [1:0] lay);
    cfg_t c;
    c.addressing_24bit = a24;
    c.ram_base = ram_b;
    c.ram_bytes = ram_n;
    c.rom_base = rom_b;
    c.rom_bytes = rom_n;
    c.frame_base = fb_b;
    c.frame_bytes = fb_n;
    c.frame_layout = lay;
    return c;
  endfunction

  function automatic cfg_t random_config();
    return make_cfg(1'($urandom_range(0, 1)), $urandom, $urandom >> $urandom_range(4, 31),
                    $urandom, $urandom >> $urandom_range(4, 31),
                    $urandom, $urandom >> $urandom_range(8, 31), 2'($urandom_range(0, 3)));
  endfunction

  function automatic in_t make_access(logic [2:0] op, logic [31:0] addr,
                                      logic [31:0] wd, logic [31:0] sd);
    in_t a;
    a.opcode = op;
    a.address = addr;
    a.write_data = wd;
    a.store_data = sd;
    return a;
  endfunction

  function automatic in_t random_access();
    in_t               a;
    int                pick;
    logic [31:0]       base;
    logic [31:0]       span;
    longint unsigned   reach;
    pick = $urandom_range(0, 49);
    if (pick == 0) a.opcode = OP_NOP6;
    else if (pick == 1) a.opcode = OP_NOP7;
    else a.opcode = 3'($urandom_range(OP_RD_B, OP_WR_L));
    case ($urandom_range(0, 3))
      0: begin base = sb.cfg.ram_base;   span = sb.cfg.ram_bytes;   end
      1: begin base = sb.cfg.rom_base;   span = sb.cfg.rom_bytes;   end
      2: begin base = sb.cfg.frame_base; span = sb.cfg.frame_bytes; end
      default: begin base = $urandom; span = $urandom; end
    endcase
    reach = {32'h0, span} + 64'h20000;
    case ($urandom_range(0, 3))
      0: a.address = base - $urandom_range(1, 'h20000);
      1: a.address = base + span - $urandom_range(0, 'h100);
      default: a.address = base + 32'($urandom % reach);
    endcase
    // mirrored copies in 24-bit mode
    if (sb.cfg.addressing_24bit && $urandom_range(0, 1)) a.address[31:24] = 8'($urandom);
    a.write_data = $urandom;
    a.store_data = $urandom;
    return a;
  endfunction

  task automatic send_directed();
    logic [2:0] op;
    for (int k = 0; k < 8; k++) begin
      op = 3'(k);
      drive_beat(make_access(op, sb.cfg.frame_base + 32'h10, 32'hfedc_ba98, 32'h8421_f00f));
    end
    drive_beat(make_access(OP_RD_L, 32'h0000_1234, 32'h0, 32'h1122_3344));
    drive_beat(make_access(OP_WR_W, 32'h0000_1234, 32'hffff_abcd, 32'h0));
    drive_beat(make_access(OP_WR_B, 32'h0000_0001, 32'hffff_ff5a, 32'h0));
    drive_beat(make_access(OP_RD_W, sb.cfg.rom_base + 32'h100, 32'h0, 32'haabb_ccdd));
    drive_beat(make_access(OP_WR_L, sb.cfg.rom_base + 32'h100, 32'h1234_5678, 32'h0));
    drive_beat(make_access(OP_RD_L, 32'h2000_0000, 32'h0, 32'hffff_ffff));
    drive_beat(make_access(OP_WR_L, 32'h2000_0000, 32'hffff_ffff, 32'h0));
    drive_beat(make_access(OP_RD_B, 32'h0000_0000, 32'h0, 32'hffff_ffff));
    drive_beat(make_access(OP_WR_L, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff));
    drive_beat(make_access(OP_RD_L, 32'hffff_ffff, 32'h0, 32'h0));
    drive_beat(make_access(OP_RD_L, sb.cfg.ram_base + sb.cfg.ram_bytes - 32'h1, 32'h0,
                           32'h0102_0304));
    drive_beat(make_access(OP_RD_L, sb.cfg.ram_base + sb.cfg.ram_bytes, 32'h0,
                           32'h0102_0304));
  endtask

  task automatic run_traffic(int n);
    int sent;
    int burst;
    sent = 0;
    while (sent < n) begin
      burst = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 120) : $urandom_range(1, 20);
      repeat (burst) begin
        drive_beat(random_access());
        sent++;
      end
      if ($urandom_range(0, 2) != 0) idle_input($urandom_range(1, 12));
    end
  endtask

  initial begin
    cfg_t phases[10];
    phases[0] = make_cfg(1'b0, 32'h0000_0000, 32'h0080_0000, 32'h4080_0000, 32'h0010_0000,
                         32'ha000_0000, 32'h0004_b000, FB_DIRECT);
    phases[1] = make_cfg(1'b0, 32'h0000_0000, 32'h0200_0000, 32'h4080_0000, 32'h0008_0000,
                         32'h8000_0000, 32'h0012_c000, FB_555);
    // frame wraps past the top bank, RAM clipped to the ROM base
    phases[2] = make_cfg(1'b0, 32'h1000_0000, 32'hffff_ffff, 32'h2000_0000, 32'h0020_0000,
                         32'hffff_0000, 32'h0002_0000, FB_565);
    phases[3] = make_cfg(1'b0, 32'h0000_0000, 32'h0100_0000, 32'h4080_0000, 32'h0010_0000,
                         32'h4080_0000, 32'h0001_0000, FB_888);
    phases[4] = make_cfg(1'b1, 32'h0000_0000, 32'h0040_0000, 32'h0040_0000, 32'h0004_0000,
                         32'h00f0_0000, 32'h0001_5000, FB_565);
    phases[5] = make_cfg(1'b1, 32'h0100_0000, 32'h0100_0000, 32'h0300_0000, 32'h0100_0000,
                         32'h0000_0000, 32'h00ff_ffff, FB_555);
    phases[6] = make_cfg(1'b0, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
                         32'hffff_ffff, 32'hffff_ffff, FB_888);
    phases[7] = make_cfg(1'b1, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, FB_DIRECT);
    phases[8] = random_config();
    phases[9] = random_config();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    for (int k = 0; k < 10; k++) begin
      load_config(phases[k]);
      if (k == 0) send_directed();
      if (k == 2) hold_off = 1'b1;
      run_traffic(200);
      settle();
    end
    sb.finish_check();
    if (sb.failures == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/gmmd_pkg.sv
rtl/gmmd_fifo.sv
rtl/gmmd_front.sv
rtl/gmmd_back.sv
rtl/guest_memory_map_decoder.sv
rtl/gmmd_checker.sv
verif/tb_top.sv
